// File: rtl/sc3x_pkg.sv
// Package for the three-times column upscaler.
// Holds the pixel and item types, the output queue size and the corner rule.
// Depends on nothing.
`default_nettype none

package sc3x_pkg;

  localparam int unsigned PixelBits = 32;
  localparam int unsigned FieldBits = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
  localparam int unsigned QueueCntBits = $clog2(QueueDepth + 1);

  typedef logic [PixelBits-1:0] pixel_t;
  typedef logic [FieldBits-1:0] field_t;

  typedef enum logic [1:0] {
    SeenNone = 2'd0,
    SeenOne  = 2'd1,
    SeenTwo  = 2'd2
  } seen_e;

  typedef struct packed {
    field_t pix_above;
    field_t pix_center;
    field_t pix_below;
    logic   row_end;
  } in_item_t;

  typedef struct packed {
    field_t out_top_left;
    field_t out_top_mid;
    field_t out_top_right;
    field_t out_mid_left;
    field_t out_mid_mid;
    field_t out_mid_right;
    field_t out_bot_left;
    field_t out_bot_mid;
    field_t out_bot_right;
    logic   row_last;
  } out_item_t;

  typedef struct packed {
    pixel_t above;
    pixel_t center;
    pixel_t below;
  } column_t;

  typedef struct packed {
    logic   has_left;
    pixel_t left;
    logic   has_right;
    pixel_t right;
    logic   last;
  } nbr_t;

  // A corner takes v when the near neighbor matches it and both the opposite
  // vertical pixel and the far neighbor differ from it.
  function automatic pixel_t corner(pixel_t v, pixel_t opp, pixel_t c,
                                    logic has_near, pixel_t near_px,
                                    logic has_far, pixel_t far_px);
    logic take;
    take = has_near && (near_px == v) && (opp != v) && !(has_far && (far_px == v));
    return take ? v : c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sc3x_block.sv
// Builds one 3x3 output block from a source column and its row neighbors.
// Purely combinational; depends on sc3x_pkg.
`default_nettype none

module sc3x_block (
  input  wire sc3x_pkg::column_t col_i,
  input  wire sc3x_pkg::nbr_t    nbr_i,
  output sc3x_pkg::out_item_t    blk_o
);

  sc3x_pkg::field_t c_f;

  assign c_f = sc3x_pkg::FieldBits'(col_i.center);

  always_comb begin
    blk_o.out_top_left  = sc3x_pkg::FieldBits'(sc3x_pkg::corner(
        col_i.above, col_i.below, col_i.center,
        nbr_i.has_left, nbr_i.left, nbr_i.has_right, nbr_i.right));
    blk_o.out_top_mid   = c_f;
    blk_o.out_top_right = sc3x_pkg::FieldBits'(sc3x_pkg::corner(
        col_i.above, col_i.below, col_i.center,
        nbr_i.has_right, nbr_i.right, nbr_i.has_left, nbr_i.left));
    blk_o.out_mid_left  = c_f;
    blk_o.out_mid_mid   = c_f;
    blk_o.out_mid_right = c_f;
    blk_o.out_bot_left  = sc3x_pkg::FieldBits'(sc3x_pkg::corner(
        col_i.below, col_i.above, col_i.center,
        nbr_i.has_left, nbr_i.left, nbr_i.has_right, nbr_i.right));
    blk_o.out_bot_mid   = c_f;
    blk_o.out_bot_right = sc3x_pkg::FieldBits'(sc3x_pkg::corner(
        col_i.below, col_i.above, col_i.center,
        nbr_i.has_right, nbr_i.right, nbr_i.has_left, nbr_i.left));
    blk_o.row_last      = nbr_i.last;
  end

endmodule

`default_nettype wire

// File: rtl/sc3x_queue.sv
// Small output queue that takes up to two blocks per cycle and gives one while ready_i is high.
// Depends on sc3x_pkg.
`default_nettype none

module sc3x_queue (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      push0_i,
  input  wire sc3x_pkg::out_item_t data0_i,
  input  wire                      push1_i,
  input  wire sc3x_pkg::out_item_t data1_i,
  output logic                     room_two_o,
  output logic                     valid_o,
  input  wire                      ready_i,
  output sc3x_pkg::out_item_t      data_o
);

  sc3x_pkg::out_item_t mem_q [sc3x_pkg::QueueDepth];
  logic [sc3x_pkg::QueuePtrBits-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [sc3x_pkg::QueueCntBits-1:0] count_q, count_d;
  logic pop;

  assign pop        = valid_o && ready_i;
  assign valid_o    = (count_q != '0);
  assign data_o     = mem_q[rptr_q];
  assign room_two_o = (count_q <= sc3x_pkg::QueueCntBits'(sc3x_pkg::QueueDepth - 2));

  always_comb begin
    wptr_d  = wptr_q + sc3x_pkg::QueuePtrBits'(push0_i)
                     + sc3x_pkg::QueuePtrBits'(push1_i);
    rptr_d  = rptr_q + sc3x_pkg::QueuePtrBits'(pop);
    count_d = count_q + sc3x_pkg::QueueCntBits'(push0_i)
                      + sc3x_pkg::QueueCntBits'(push1_i)
                      - sc3x_pkg::QueueCntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wptr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wptr_q + sc3x_pkg::QueuePtrBits'(1)] <= data1_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sc3x_pkg::QueueCntBits'(sc3x_pkg::QueueDepth))
    else $error("output queue holds more items than it has entries");

  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i)
    else $error("second block pushed without the first");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> (count_q <= sc3x_pkg::QueueCntBits'(sc3x_pkg::QueueDepth - 2)))
    else $error("two blocks pushed without room for both");

  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0_i && !pop |=> valid_o)
    else $error("pushed item not visible at the output");
`endif

endmodule

`default_nettype wire

// File: rtl/scale3x_column_upscaler_core.sv
// Three-times column upscaler: one source column in, 3x3 output blocks out.
// Depends on sc3x_pkg, sc3x_block and sc3x_queue.
//
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_ready_o    in_item_i  (sc3x_pkg::in_item_t)
// output    out        out_valid_o / out_ready_i  out_item_o (sc3x_pkg::out_item_t)
//
// One column is taken per cycle; its block leaves one item later through a
// four-entry output queue, and a row end adds a second block.
// The queue sets the rate: input is taken while at least two entries are free.
// Reset clears the column window and the queue; the first item starts a row.
// A stalled output fills the queue, after which the input is held off.
`default_nettype none

module scale3x_column_upscaler_core (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire sc3x_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output sc3x_pkg::out_item_t     out_item_o
);

  logic in_accept;
  sc3x_pkg::column_t cur_col, held_q, held_d;
  sc3x_pkg::pixel_t left_q, left_d;
  sc3x_pkg::seen_e seen_q, seen_d;
  sc3x_pkg::nbr_t nbr0, nbr1;
  sc3x_pkg::out_item_t blk0, blk1;
  logic push0, push1, room_two;

  assign in_ready_o = room_two;
  assign in_accept  = in_valid_i && in_ready_o;

  assign cur_col.above  = in_item_i.pix_above[sc3x_pkg::PixelBits-1:0];
  assign cur_col.center = in_item_i.pix_center[sc3x_pkg::PixelBits-1:0];
  assign cur_col.below  = in_item_i.pix_below[sc3x_pkg::PixelBits-1:0];

  always_comb begin
    nbr0.has_left  = (seen_q == sc3x_pkg::SeenTwo);
    nbr0.left      = left_q;
    nbr0.has_right = 1'b1;
    nbr0.right     = cur_col.center;
    nbr0.last      = 1'b0;
    nbr1.has_left  = 1'b1;
    nbr1.left      = held_q.center;
    nbr1.has_right = 1'b0;
    nbr1.right     = '0;
    nbr1.last      = 1'b1;
  end

  sc3x_block u_blk_held (
    .col_i (held_q),
    .nbr_i (nbr0),
    .blk_o (blk0)
  );

  sc3x_block u_blk_end (
    .col_i (cur_col),
    .nbr_i (nbr1),
    .blk_o (blk1)
  );

  assign push0 = in_accept && (seen_q != sc3x_pkg::SeenNone);
  assign push1 = push0 && in_item_i.row_end;

  always_comb begin
    held_d = held_q;
    left_d = left_q;
    seen_d = seen_q;
    if (in_accept) begin
      if (in_item_i.row_end) begin
        held_d = '0;
        left_d = '0;
        seen_d = sc3x_pkg::SeenNone;
      end else begin
        held_d = cur_col;
        left_d = held_q.center;
        case (seen_q)
          sc3x_pkg::SeenNone: seen_d = sc3x_pkg::SeenOne;
          sc3x_pkg::SeenOne:  seen_d = sc3x_pkg::SeenTwo;
          default:            seen_d = sc3x_pkg::SeenTwo;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      left_q <= '0;
      seen_q <= sc3x_pkg::SeenNone;
    end else begin
      held_q <= held_d;
      left_q <= left_d;
      seen_q <= seen_d;
    end
  end

  sc3x_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push0_i    (push0),
    .data0_i    (blk0),
    .push1_i    (push1),
    .data1_i    (blk1),
    .room_two_o (room_two),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_row_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_item_i.row_end |=> seen_q == sc3x_pkg::SeenNone)
    else $error("window not back at row start after a row end");

  a_first_column_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q == sc3x_pkg::SeenNone |-> !push0)
    else $error("block pushed at row start");

  a_held_center_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !in_item_i.row_end |=> held_q.center == $past(cur_col.center))
    else $error("held column not loaded from the accepted item");
`endif

endmodule

`default_nettype wire
